### hw/rtl/box_filter_3x3_rgb_defines.svh
// Assertion helpers for the box filter. Each macro expects clk_i and rst_ni
// to be visible at the place of use.
`ifndef BOX_FILTER_3X3_RGB_DEFINES_SVH
`define BOX_FILTER_3X3_RGB_DEFINES_SVH

// Same-cycle implication.
`define BF3_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BF3_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/bf3_pkg.sv
package bf3_pkg;

  localparam int unsigned NUM_CH = 3;
  localparam int unsigned CH_RED = 0;
  localparam int unsigned CH_GREEN = 1;
  localparam int unsigned CH_BLUE = 2;

  localparam int unsigned CFG_W = 9;
  localparam logic [0:0] CFG_IMAGE_WIDTH = 1'b0;
  localparam logic [0:0] CFG_IMAGE_HEIGHT = 1'b1;
  localparam logic [CFG_W-1:0] IMAGE_WIDTH_RST = 9'd220;
  localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RST = 9'd220;

  // Sum of nine 8-bit samples plus the rounding bias fits in 12 bits.
  localparam int unsigned SUM_W = 12;
  localparam int unsigned ROUND_BIAS = 4;
  // floor(x/9) == (x * 7282) >> 16 for every x below 2300.
  localparam int unsigned RECIP_W = 13;
  localparam logic [RECIP_W-1:0] RECIP_9 = 13'd7282;
  localparam int unsigned RECIP_SHIFT = 16;
  localparam int unsigned PIX_MAX = 255;

  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned FIFO_AW = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W = FIFO_AW + 1;

  typedef logic [NUM_CH-1:0][7:0] rgb_t;

  // Window indexed [column][row]; column 2 is the newest, row 0 the top.
  typedef rgb_t [2:0][2:0] win_t;

  typedef struct packed {
    logic [7:0] row;
    logic [7:0] col;
    logic       last;
  } tag_t;

  typedef struct packed {
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
    logic       frame_start;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_row;
    logic [7:0] out_col;
    logic       frame_last;
  } pix_out_t;

endpackage

### hw/rtl/bf3_stream_if.sv
interface bf3_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/bf3_line_ram.sv
module bf3_line_ram
  import bf3_pkg::*;
#(
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  rgb_t                     wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output rgb_t                     rd_data_o
);

  rgb_t mem [DEPTH];
  rgb_t rd_data_q;

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### hw/rtl/bf3_mean.sv
module bf3_mean
  import bf3_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     vld_i,
  input  win_t     win_i,
  input  tag_t     tag_i,
  output logic     vld_o,
  output pix_out_t res_o
);

  localparam int unsigned PROD_W = SUM_W + RECIP_W;
  localparam int unsigned QUO_W = PROD_W - RECIP_SHIFT;

  logic [NUM_CH-1:0][SUM_W-1:0] sum_d, sum_q;
  logic                         vld_q;
  tag_t                         tag_q;
  logic [NUM_CH-1:0][7:0]       mean;

  // First stage: biased channel sums over the window.
  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      sum_d[k] = SUM_W'(ROUND_BIAS);
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          sum_d[k] = sum_d[k] + SUM_W'(win_i[c][r][k]);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_i) begin
      sum_q <= sum_d;
      tag_q <= tag_i;
    end
  end

  // Second stage: divide by nine through the reciprocal, then clamp.
  always_comb begin
    logic [PROD_W-1:0] prod;
    logic [QUO_W-1:0]  quo;
    for (int k = 0; k < NUM_CH; k++) begin
      prod = PROD_W'(sum_q[k]) * PROD_W'(RECIP_9);
      quo = prod[PROD_W-1:RECIP_SHIFT];
      mean[k] = (quo > QUO_W'(PIX_MAX)) ? 8'(PIX_MAX) : quo[7:0];
    end
  end

  assign vld_o = vld_q;
  assign res_o.out_red = mean[CH_RED];
  assign res_o.out_green = mean[CH_GREEN];
  assign res_o.out_blue = mean[CH_BLUE];
  assign res_o.out_row = tag_q.row;
  assign res_o.out_col = tag_q.col;
  assign res_o.frame_last = tag_q.last;

endmodule

### hw/rtl/bf3_out_fifo.sv
module bf3_out_fifo
  import bf3_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     wr_en_i,
  input  pix_out_t wr_data_i,
  bf3_stream_if.source res_o
);

  pix_out_t               mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]       cnt_q;
  logic                   pop;

  assign pop = res_o.valid && res_o.ready;

  // The upstream credit count keeps writes from ever finding the queue full.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_en_i) begin
        wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
      end
      unique case ({wr_en_i, pop})
        2'b10:   cnt_q <= cnt_q + CNT_W'(1);
        2'b01:   cnt_q <= cnt_q - CNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  assign res_o.valid = (cnt_q != '0);
  assign res_o.data = mem_q[rd_ptr_q];

endmodule

### hw/rtl/box_filter_3x3_rgb.sv
// Channel   Dir  Handshake             Payload
// pix_i     in   pix_i.valid/ready     pixel_red, pixel_green, pixel_blue, frame_start
// res_o     out  res_o.valid/ready     out_red/green/blue, out_row, out_col, frame_last
// cfg       in   cfg_we_i (no ready)   cfg_idx_i, cfg_data_i
//
// One pixel beat is accepted per clock; the line store read-modify-write and the
// window shift run at that rate. A result beat passes the stage 1, window and
// mean registers, then is held in an eight-entry output queue.
// Ready drops only when eight results are reserved in flight or queued.
// Reset is asynchronous and active low; the scan then waits for frame_start.
// The line stores have no reset and need no clearing pass.

`include "box_filter_3x3_rgb_defines.svh"

module box_filter_3x3_rgb
  import bf3_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 256,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  bf3_stream_if.sink       pix_i,
  bf3_stream_if.source     res_o,
  input  logic             cfg_we_i,
  input  logic [0:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  // Column counter runs to the width itself; the line stores need one entry
  // per image column only.
  localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned DWW = (CW > CFG_W) ? CW : CFG_W;
  localparam int unsigned DWH = (RW > CFG_W) ? RW : CFG_W;

  // Configuration registers. Out-of-range values are folded into 1..MAX.
  logic [CFG_W-1:0] image_width_q, image_height_q;
  logic [DWW-1:0]   w_ext;
  logic [DWH-1:0]   h_ext;
  logic [CW-1:0]    w_eff;
  logic [RW-1:0]    h_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q <= IMAGE_WIDTH_RST;
      image_height_q <= IMAGE_HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IMAGE_WIDTH:  image_width_q <= cfg_data_i;
        CFG_IMAGE_HEIGHT: image_height_q <= cfg_data_i;
      endcase
    end
  end

  assign w_ext = DWW'(image_width_q);
  assign h_ext = DWH'(image_height_q);

  always_comb begin
    if (w_ext == '0) begin
      w_eff = CW'(1);
    end else if (w_ext > DWW'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(w_ext);
    end
    if (h_ext == '0) begin
      h_eff = RW'(1);
    end else if (h_ext > DWH'(MAX_HEIGHT)) begin
      h_eff = RW'(MAX_HEIGHT);
    end else begin
      h_eff = RW'(h_ext);
    end
  end

  // Scan position. frame_start overrides the stored position for its own beat.
  logic [RW-1:0] row_q, row_d, r_cur, rm1;
  logic [CW-1:0] col_q, col_d, c_cur, cm1;
  logic          done_q, done_d, done_cur;
  logic          acc, active, col_in, row_in, rd_en, emit_cur, last_cur, take;
  logic [AW-1:0] rd_addr;
  rgb_t          px_in, px_d;

  assign acc = pix_i.valid && pix_i.ready;
  assign r_cur = pix_i.data.frame_start ? '0 : row_q;
  assign c_cur = pix_i.data.frame_start ? '0 : col_q;
  assign done_cur = pix_i.data.frame_start ? 1'b0 : done_q;
  assign active = acc && !done_cur;
  assign col_in = (c_cur < w_eff);
  assign row_in = (r_cur < h_eff);
  assign rd_en = active && col_in;
  assign rd_addr = c_cur[AW-1:0];
  assign emit_cur = (r_cur != '0) && (c_cur != '0) && (r_cur <= h_eff) && (c_cur <= w_eff);
  assign last_cur = (r_cur == h_eff) && (c_cur == w_eff);
  assign take = active && emit_cur;
  assign rm1 = r_cur - RW'(1);
  assign cm1 = c_cur - CW'(1);

  assign px_in[CH_RED] = pix_i.data.pixel_red;
  assign px_in[CH_GREEN] = pix_i.data.pixel_green;
  assign px_in[CH_BLUE] = pix_i.data.pixel_blue;
  // Samples past the right or bottom edge enter as zero.
  assign px_d = (col_in && row_in) ? px_in : '0;

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    done_d = done_q;
    if (acc) begin
      row_d = r_cur;
      col_d = c_cur;
      done_d = done_cur;
      if (!done_cur) begin
        if (!col_in) begin
          col_d = '0;
          if (r_cur >= h_eff) begin
            done_d = 1'b1;
          end else begin
            row_d = r_cur + RW'(1);
          end
        end else begin
          col_d = c_cur + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
      done_q <= 1'b1;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
      done_q <= done_d;
    end
  end

  // Stage 1: line store data is back. A write from the previous beat to the
  // same column is forwarded, since the store returns old data on a collision.
  logic          s1_vld_q, s1_clr_q, s1_incol_q, s1_r1_q, s1_r2_q, s1_emit_q;
  logic          s1_fwd_q, s1_wr_en;
  logic [AW-1:0] s1_addr_q;
  rgb_t          s1_px_q, s1_fwd_up_q, s1_fwd_lo_q;
  tag_t          s1_tag_q;
  rgb_t          up_ram, lo_ram, up_rd, lo_rd, top_px, mid_px;

  assign s1_wr_en = s1_vld_q && s1_incol_q;
  assign up_rd = s1_fwd_q ? s1_fwd_up_q : up_ram;
  assign lo_rd = s1_fwd_q ? s1_fwd_lo_q : lo_ram;
  assign top_px = (s1_incol_q && s1_r2_q) ? up_rd : '0;
  assign mid_px = (s1_incol_q && s1_r1_q) ? lo_rd : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= active;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_clr_q <= (c_cur == '0);
    s1_incol_q <= col_in;
    s1_r1_q <= (r_cur != '0);
    s1_r2_q <= (r_cur > RW'(1));
    s1_emit_q <= emit_cur;
    s1_addr_q <= rd_addr;
    s1_px_q <= px_d;
    s1_tag_q.row <= 8'(rm1);
    s1_tag_q.col <= 8'(cm1);
    s1_tag_q.last <= last_cur;
    s1_fwd_q <= s1_wr_en && rd_en && (s1_addr_q == rd_addr);
    s1_fwd_up_q <= lo_rd;
    s1_fwd_lo_q <= s1_px_q;
  end

  // The upper store takes what the lower store held; the lower store takes
  // the new row.
  bf3_line_ram #(
    .DEPTH(MAX_WIDTH)
  ) u_upper (
    .clk_i    (clk_i),
    .wr_en_i  (s1_wr_en),
    .wr_addr_i(s1_addr_q),
    .wr_data_i(lo_rd),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(up_ram)
  );

  bf3_line_ram #(
    .DEPTH(MAX_WIDTH)
  ) u_lower (
    .clk_i    (clk_i),
    .wr_en_i  (s1_wr_en),
    .wr_addr_i(s1_addr_q),
    .wr_data_i(s1_px_q),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(lo_ram)
  );

  // Window shift. The first column of a row starts from an empty window so
  // the left border pads with zeros.
  win_t win_q, win_d;
  logic e_vld_q;
  tag_t e_tag_q;

  always_comb begin
    win_d = win_q;
    if (s1_vld_q) begin
      win_d[0] = s1_clr_q ? '0 : win_q[1];
      win_d[1] = s1_clr_q ? '0 : win_q[2];
      win_d[2][0] = top_px;
      win_d[2][1] = mid_px;
      win_d[2][2] = s1_px_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
      e_vld_q <= 1'b0;
    end else begin
      win_q <= win_d;
      e_vld_q <= s1_vld_q && s1_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    e_tag_q <= s1_tag_q;
  end

  // Mean over the window, then the output queue.
  logic     m_vld;
  pix_out_t m_res;

  bf3_mean u_mean (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .vld_i (e_vld_q),
    .win_i (win_q),
    .tag_i (e_tag_q),
    .vld_o (m_vld),
    .res_o (m_res)
  );

  bf3_out_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (m_vld),
    .wr_data_i(m_res),
    .res_o    (res_o)
  );

  // Credits count results that are in the pipe or waiting in the queue, so
  // the queue can never overflow and ready does not depend on res_o.ready
  // within the same cycle.
  logic [CNT_W-1:0] credit_q;
  logic             pop;

  assign pop = res_o.valid && res_o.ready;
  assign pix_i.ready = (credit_q < CNT_W'(FIFO_DEPTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_q <= '0;
    end else begin
      unique case ({take, pop})
        2'b10:   credit_q <= credit_q + CNT_W'(1);
        2'b01:   credit_q <= credit_q - CNT_W'(1);
        default: credit_q <= credit_q;
      endcase
    end
  end

  // The final result of a frame always ends the scan.
  `BF3_ASSERT_NEXT(a_last_ends_scan, take && last_cur, done_q, "frame end did not stop the scan")
  // A queued result must still be covered by a credit.
  `BF3_ASSERT_IMP(a_res_has_credit, res_o.valid, credit_q != '0, "result without a credit")
  // Starting a row leaves only the new column in the window.
  `BF3_ASSERT_NEXT(a_win_clear, s1_vld_q && s1_clr_q, (win_q[0] == '0) && (win_q[1] == '0),
                   "window not cleared at row start")

endmodule
